// ----- rtl/core/fbc_pkg.sv -----
// Shared types, constants and round functions for the 64-bit Feistel block cipher.
package fbc_pkg;

	// Network geometry.
	localparam int unsigned ROUNDS        = 32;
	localparam int unsigned HALF_W        = 32;
	localparam int unsigned BLOCK_W       = 2 * HALF_W;
	localparam int unsigned KEY_WORDS     = 8;
	localparam int unsigned ROT_AMOUNT    = 11;
	localparam int unsigned FWD_PHASE_ENC = 24;
	localparam int unsigned FWD_PHASE_DEC = 8;
	localparam int unsigned NIBBLES       = HALF_W / 4;

	localparam int unsigned ROUND_W  = $clog2(ROUNDS);
	localparam int unsigned KIDX_W   = $clog2(KEY_WORDS);
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_01    = 3'd0,
		CFG_KEY_23    = 3'd1,
		CFG_KEY_45    = 3'd2,
		CFG_KEY_67    = 3'd3,
		CFG_DIRECTION = 3'd4
	} cfg_reg_t;

	// Direction codes.
	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	// Data handed from one round cell to the next.
	typedef struct packed {
		logic              valid;
		logic [HALF_W-1:0] n1;
		logic [HALF_W-1:0] n2;
	} fbc_stage_t;

	// Substitution rows; nibble i of the word uses row i.
	localparam logic [3:0] SBOX [0:7][0:15] = '{
		'{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
		  4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
		'{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
		  4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
		'{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
		  4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
		'{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
		  4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
		'{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
		  4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
		'{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
		  4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
		'{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
		  4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
		'{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
		  4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
	};

	// Eight parallel 4-bit substitutions.
	function automatic logic [HALF_W-1:0] substitute(input logic [HALF_W-1:0] x);
		logic [HALF_W-1:0] y;
		y = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			y[4*i +: 4] = SBOX[i][x[4*i +: 4]];
		end
		return y;
	endfunction

	// Round function: add key, substitute, rotate left.
	function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] n1,
			input logic [HALF_W-1:0] k);
		logic [HALF_W-1:0] s;
		s = substitute(n1 + k);
		return (s << ROT_AMOUNT) | (s >> (HALF_W - ROT_AMOUNT));
	endfunction

	// Key word used by a round: forward order first, then reversed.
	function automatic logic [KIDX_W-1:0] key_index(input logic [ROUND_W-1:0] rnd,
			input logic dir);
		logic [ROUND_W:0] fwd;
		fwd = (dir == DIR_DECRYPT) ? (ROUND_W+1)'(FWD_PHASE_DEC)
		                           : (ROUND_W+1)'(FWD_PHASE_ENC);
		if ({1'b0, rnd} < fwd) begin
			return rnd[KIDX_W-1:0];
		end
		return KIDX_W'(KEY_WORDS - 1) - rnd[KIDX_W-1:0];
	endfunction

endpackage

// ----- rtl/core/fbc_round_cell.sv -----
// One Feistel round as a cell of the pipeline chain.
module fbc_round_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fbc_pkg::fbc_stage_t              stage_in,
	input  logic [fbc_pkg::HALF_W-1:0]       round_key,
	output fbc_pkg::fbc_stage_t              stage_out
);

	logic                       valid_s1;
	logic [fbc_pkg::HALF_W-1:0] n1_s1;
	logic [fbc_pkg::HALF_W-1:0] n2_s1;
	logic [fbc_pkg::HALF_W-1:0] mixed;

	// The new left half is the round function XORed into the right half.
	assign mixed = fbc_pkg::round_fn(stage_in.n1, round_key) ^ stage_in.n2;

	// Occupancy of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	// Halves swap on the way to the next cell.
	always_ff @(posedge clk) begin
		n1_s1 <= mixed;
		n2_s1 <= stage_in.n1;
	end

	assign stage_out.valid = valid_s1;
	assign stage_out.n1    = n1_s1;
	assign stage_out.n2    = n2_s1;

endmodule

// ----- rtl/core/feistel_block_cipher_64.sv -----
// Top level of the 64-bit Feistel block cipher: key registers and the chain of round cells.
//
// Usage:
//   Input channel: raise start with a block on in_block. The transaction is taken at
//   the rising edge where start is high and busy is low. busy is high only while the
//   block comes out of reset; after that one block can be taken in every cycle.
//   Result channel: done pulses for one cycle with out_block. The receiver cannot
//   stall it, so it must take every result in the cycle it is shown.
//   Configuration channel: cfg_valid with cfg_index and cfg_data; cfg_ready is
//   always high, so a write completes in the cycle it is offered. Indexes 0 to 3
//   load key word pairs, index 4 selects the direction (bit 0), others are ignored.
//   Write configuration only while no block is in flight.
// Pipeline:
//   A block taken at one edge passes through the chain of 32 cells, one register per
//   cell; done rises with the result when the block leaves the last cell. Once busy
//   is low, throughput is one block per cycle.
// Reset:
//   arst_n clears the key, the direction and every cell's occupancy; blocks in
//   flight are dropped and no result follows them.
module feistel_block_cipher_64 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [fbc_pkg::BLOCK_W-1:0]         in_block,
	output logic                                done,
	output logic [fbc_pkg::BLOCK_W-1:0]         out_block,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fbc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [fbc_pkg::HALF_W-1:0] key_q [fbc_pkg::KEY_WORDS];
	logic                       dir_q;
	logic                       busy_q;
	logic [fbc_pkg::HALF_W-1:0] round_key [fbc_pkg::ROUNDS];
	fbc_pkg::fbc_stage_t        chain [fbc_pkg::ROUNDS+1];

	// Busy only straight after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fbc_pkg::KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
			dir_q <= fbc_pkg::DIR_ENCRYPT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fbc_pkg::CFG_KEY_01: begin
					key_q[0] <= cfg_data[63:32];
					key_q[1] <= cfg_data[31:0];
				end
				fbc_pkg::CFG_KEY_23: begin
					key_q[2] <= cfg_data[63:32];
					key_q[3] <= cfg_data[31:0];
				end
				fbc_pkg::CFG_KEY_45: begin
					key_q[4] <= cfg_data[63:32];
					key_q[5] <= cfg_data[31:0];
				end
				fbc_pkg::CFG_KEY_67: begin
					key_q[6] <= cfg_data[63:32];
					key_q[7] <= cfg_data[31:0];
				end
				fbc_pkg::CFG_DIRECTION: begin
					dir_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Head of the chain: the accepted block enters the first cell directly.
	assign chain[0].valid = start && !busy_q;
	assign chain[0].n1    = in_block[fbc_pkg::BLOCK_W-1:fbc_pkg::HALF_W];
	assign chain[0].n2    = in_block[fbc_pkg::HALF_W-1:0];

	// One cell per round; each round's key word is fixed for either direction.
	for (genvar g = 0; g < fbc_pkg::ROUNDS; g++) begin : g_round
		localparam logic [fbc_pkg::KIDX_W-1:0] EncIdx =
			fbc_pkg::key_index(fbc_pkg::ROUND_W'(g), fbc_pkg::DIR_ENCRYPT);
		localparam logic [fbc_pkg::KIDX_W-1:0] DecIdx =
			fbc_pkg::key_index(fbc_pkg::ROUND_W'(g), fbc_pkg::DIR_DECRYPT);

		assign round_key[g] = (dir_q == fbc_pkg::DIR_DECRYPT) ? key_q[DecIdx]
		                                                      : key_q[EncIdx];

		fbc_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (chain[g]),
			.round_key (round_key[g]),
			.stage_out (chain[g+1])
		);
	end

	// Tail of the chain: final N2 in the upper half, final N1 in the lower.
	assign done      = chain[fbc_pkg::ROUNDS].valid;
	assign out_block = {chain[fbc_pkg::ROUNDS].n2, chain[fbc_pkg::ROUNDS].n1};

endmodule

// ----- rtl/core/fbc_checker.sv -----
// Port-level checks for the 64-bit Feistel block cipher, bound to the top level.
module fbc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [fbc_pkg::BLOCK_W-1:0]         in_block,
	input  logic                                done,
	input  logic [fbc_pkg::BLOCK_W-1:0]         out_block,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready
);

	logic accept;

	assign accept = start && !busy;

	// Every result comes from a matching input transaction.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, fbc_pkg::ROUNDS))
		else $error("result without a matching input transaction");

	// Every transaction taken after reset gives a result.
	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, fbc_pkg::ROUNDS + 1) && $past(accept, fbc_pkg::ROUNDS)
		|-> done)
		else $error("accepted block produced no result");

	// Once out of reset the block never refuses input.
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy raised after reset");

	// The same block taken in two successive cycles gives the same result twice.
	a_deterministic: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done)
		&& $past(in_block, fbc_pkg::ROUNDS) == $past(in_block, fbc_pkg::ROUNDS + 1)
		|-> out_block == $past(out_block))
		else $error("identical blocks gave different results");

	// A configuration write is never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind feistel_block_cipher_64 fbc_checker u_fbc_checker (.*);
